FILE: hw/rtl/gyrq_pkg.sv
// constants, default parameters and the cordic angle table shared by
// the gyro rate to quaternion pipeline; depends on nothing
package gyrq_pkg;

  localparam int RATE_BITS_DEF     = 24;
  localparam int OUT_BITS_DEF      = 32;
  localparam int CORDIC_STAGES_DEF = 28;

  localparam int DT_BITS = 24;
  // cordic datapath width, q30 with headroom for gain and angle overshoot
  localparam int CW_BITS = 34;
  // quotient bits of the axis scaling divider
  localparam int QUO_BITS = 32;

  localparam logic [43:0] TWO_PI_Q41  = 44'hC90FDAA2217;
  localparam logic [43:0] PI_Q41      = 44'h6487ED5110B;
  localparam logic [43:0] HALF_PI_Q41 = 44'h3243F6A8886;

  localparam logic signed [CW_BITS-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  // atan(2^-i) in q30
  function automatic logic signed [CW_BITS-1:0] atan_q30(input int i);
    logic signed [CW_BITS-1:0] a;
    case (i)
      0:       a = 34'sd843314856;
      1:       a = 34'sd497837829;
      2:       a = 34'sd263043836;
      3:       a = 34'sd133525158;
      4:       a = 34'sd67021686;
      5:       a = 34'sd33543515;
      6:       a = 34'sd16775850;
      7:       a = 34'sd8388437;
      8:       a = 34'sd4194282;
      9:       a = 34'sd2097149;
      10:      a = 34'sd1048575;
      default: a = CW_BITS'(64'd1 << ((i <= 30) ? (30 - i) : 63));
    endcase
    return a;
  endfunction

endpackage

FILE: hw/rtl/gyro_rate_to_quaternion.sv
// gyro rate sample and time step to unit quaternion, fully pipelined
// depends on gyrq_pkg for constants and the cordic angle table
// one item per cycle sustained while the output is not stalled; six mod
//   steps at defaults
// stages: squares, sum, one root bit per stage, angle product, one 2*pi
//   reduction bit per stage, fold, cordic stages, axis product, one
//   quotient bit per stage, output register; a stall freezes every stage
// reset: synchronous active low rst_n clears all valid bits
module gyro_rate_to_quaternion #(
  parameter int RATE_BITS     = gyrq_pkg::RATE_BITS_DEF,
  parameter int OUT_BITS      = gyrq_pkg::OUT_BITS_DEF,
  parameter int CORDIC_STAGES = gyrq_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [RATE_BITS-1:0]         in_rate_x,
  input  logic signed [RATE_BITS-1:0]         in_rate_y,
  input  logic signed [RATE_BITS-1:0]         in_rate_z,
  input  logic [gyrq_pkg::DT_BITS-1:0]        in_step_time,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [OUT_BITS-1:0]          out_quat_w,
  output logic signed [OUT_BITS-1:0]          out_quat_x,
  output logic signed [OUT_BITS-1:0]          out_quat_y,
  output logic signed [OUT_BITS-1:0]          out_quat_z
);

  localparam int RB  = RATE_BITS;
  localparam int DB  = gyrq_pkg::DT_BITS;
  localparam int CW  = gyrq_pkg::CW_BITS;
  localparam int QB  = gyrq_pkg::QUO_BITS;
  localparam int CS  = CORDIC_STAGES;
  localparam int SB  = 2 * RB + 2;
  localparam int NB  = RB + 1;
  localparam int HW  = NB + DB;
  localparam int RW  = ((HW > 44) ? HW : 44) + 1;
  localparam int MS  = (HW > 44) ? HW - 43 : 1;
  localparam int FW  = 46;
  localparam int PW  = RB + CW;
  localparam int DW  = PW + 1;
  localparam int VW  = CW + 2;
  localparam int TW  = VW + 10;
  localparam int FB  = OUT_BITS - 2;
  localparam int RSH = (FB < 30) ? 30 - FB : 0;
  localparam int LSH = (FB > 30) ? FB - 30 : 0;
  localparam logic signed [TW-1:0] RND = TW'((64'd1 << RSH) >> 1);
  localparam logic signed [TW-1:0] LIM = TW'(64'd1 << FB);
  localparam logic signed [FW-1:0] TP  = $signed(FW'(gyrq_pkg::TWO_PI_Q41));
  localparam logic signed [FW-1:0] PI  = $signed(FW'(gyrq_pkg::PI_Q41));
  localparam logic signed [FW-1:0] HP  = $signed(FW'(gyrq_pkg::HALF_PI_Q41));
  localparam logic signed [CW-1:0] ZLIM =
    $signed(CW'((gyrq_pkg::HALF_PI_Q41 + 44'd1024) >> 11));

  // q30 to output format, round half up, saturate
  function automatic logic [OUT_BITS-1:0] to_out(input logic signed [VW-1:0] v);
    logic signed [TW-1:0] t;
    t = TW'(v);
    t = (t + RND) >>> RSH;
    t = t <<< LSH;
    if (t > LIM) t = LIM;
    else if (t < -LIM) t = -LIM;
    return t[OUT_BITS-1:0];
  endfunction

  localparam logic [OUT_BITS-1:0] ONE_OUT = to_out(VW'(64'sd1 << 30));

  logic adv;
  logic out_valid_r;
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // squares
  logic                 a_v_r;
  logic [2*RB-1:0]      a_sq_r [3];
  logic signed [RB-1:0] a_rt_r [3];
  logic [DB-1:0]        a_dt_r;
  logic signed [2*RB-1:0] sqx, sqy, sqz;

  always_comb begin
    sqx = in_rate_x * in_rate_x;
    sqy = in_rate_y * in_rate_y;
    sqz = in_rate_z * in_rate_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) a_v_r <= 1'b0;
    else if (adv) a_v_r <= in_valid;
    if (adv) begin
      a_sq_r[0] <= $unsigned(sqx);
      a_sq_r[1] <= $unsigned(sqy);
      a_sq_r[2] <= $unsigned(sqz);
      a_rt_r[0] <= in_rate_x;
      a_rt_r[1] <= in_rate_y;
      a_rt_r[2] <= in_rate_z;
      a_dt_r    <= in_step_time;
    end
  end

  // sum of squares
  logic                 b_v_r;
  logic [SB-1:0]        b_s_r;
  logic signed [RB-1:0] b_rt_r [3];
  logic [DB-1:0]        b_dt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b_v_r <= 1'b0;
    else if (adv) b_v_r <= a_v_r;
    if (adv) begin
      b_s_r  <= SB'(a_sq_r[0]) + SB'(a_sq_r[1]) + SB'(a_sq_r[2]);
      b_rt_r <= a_rt_r;
      b_dt_r <= a_dt_r;
    end
  end

  // integer square root, one root bit per stage, msb first
  logic                 sq_v_r    [NB];
  logic [SB-1:0]        sq_rem_r  [NB];
  logic [NB-1:0]        sq_root_r [NB];
  logic signed [RB-1:0] sq_rt_r   [NB][3];
  logic [DB-1:0]        sq_dt_r   [NB];

  for (genvar j = 0; j < NB; j++) begin : g_sqrt
    localparam int B = NB - 1 - j;
    logic                 v_i;
    logic [SB-1:0]        rem_i;
    logic [NB-1:0]        root_i;
    logic signed [RB-1:0] rt_i [3];
    logic [DB-1:0]        dt_i;
    logic [SB:0]          cand;
    logic                 ge;

    if (j == 0) begin : g_first
      assign v_i    = b_v_r;
      assign rem_i  = b_s_r;
      assign root_i = '0;
      assign rt_i   = b_rt_r;
      assign dt_i   = b_dt_r;
    end else begin : g_next
      assign v_i    = sq_v_r[j-1];
      assign rem_i  = sq_rem_r[j-1];
      assign root_i = sq_root_r[j-1];
      assign rt_i   = sq_rt_r[j-1];
      assign dt_i   = sq_dt_r[j-1];
    end

    // (root + 2^b)^2 - root^2
    assign cand = ((SB+1)'(root_i) << (B + 1)) | ((SB+1)'(1) << (2 * B));
    assign ge   = {1'b0, rem_i} >= cand;

    always_ff @(posedge clk) begin
      if (!rst_n) sq_v_r[j] <= 1'b0;
      else if (adv) sq_v_r[j] <= v_i;
      if (adv) begin
        sq_rem_r[j]  <= ge ? rem_i - cand[SB-1:0] : rem_i;
        sq_root_r[j] <= ge ? (root_i | (NB'(1) << B)) : root_i;
        sq_rt_r[j]   <= rt_i;
        sq_dt_r[j]   <= dt_i;
      end
    end
  end

  // half angle, q41
  logic                 h_v_r;
  logic [HW-1:0]        h_r;
  logic [NB-1:0]        h_norm_r;
  logic signed [RB-1:0] h_rt_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) h_v_r <= 1'b0;
    else if (adv) h_v_r <= sq_v_r[NB-1];
    if (adv) begin
      h_r      <= HW'(sq_root_r[NB-1]) * HW'(sq_dt_r[NB-1]);
      h_norm_r <= sq_root_r[NB-1];
      h_rt_r   <= sq_rt_r[NB-1];
    end
  end

  // reduction modulo 2*pi, one shifted subtract per stage
  logic                 md_v_r    [MS];
  logic [RW-1:0]        md_rem_r  [MS];
  logic [NB-1:0]        md_norm_r [MS];
  logic signed [RB-1:0] md_rt_r   [MS][3];

  for (genvar j = 0; j < MS; j++) begin : g_mod
    localparam int K = MS - 1 - j;
    localparam logic [RW-1:0] DV = RW'(gyrq_pkg::TWO_PI_Q41) << K;
    logic                 v_i;
    logic [RW-1:0]        rem_i;
    logic [NB-1:0]        norm_i;
    logic signed [RB-1:0] rt_i [3];

    if (j == 0) begin : g_first
      assign v_i    = h_v_r;
      assign rem_i  = RW'(h_r);
      assign norm_i = h_norm_r;
      assign rt_i   = h_rt_r;
    end else begin : g_next
      assign v_i    = md_v_r[j-1];
      assign rem_i  = md_rem_r[j-1];
      assign norm_i = md_norm_r[j-1];
      assign rt_i   = md_rt_r[j-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) md_v_r[j] <= 1'b0;
      else if (adv) md_v_r[j] <= v_i;
      if (adv) begin
        md_rem_r[j]  <= (rem_i >= DV) ? rem_i - DV : rem_i;
        md_norm_r[j] <= norm_i;
        md_rt_r[j]   <= rt_i;
      end
    end
  end

  // fold into [-pi/2, pi/2] and round to q30
  logic                 f_v_r;
  logic signed [CW-1:0] f_z_r;
  logic                 f_neg_r;
  logic [NB-1:0]        f_norm_r;
  logic signed [RB-1:0] f_rt_r [3];
  logic signed [FW-1:0] fr, fa, fz;
  logic                 fneg;

  always_comb begin
    fr = $signed(FW'(md_rem_r[MS-1][43:0]));
    if (fr <= HP) begin
      fa = fr;
      fneg = 1'b0;
    end else if (fr <= PI) begin
      fa = fr - PI;
      fneg = 1'b1;
    end else if (fr < TP - HP) begin
      fa = fr - TP + PI;
      fneg = 1'b1;
    end else begin
      fa = fr - TP;
      fneg = 1'b0;
    end
    fz = (fa + FW'(1024)) >>> 11;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) f_v_r <= 1'b0;
    else if (adv) f_v_r <= md_v_r[MS-1];
    if (adv) begin
      f_z_r    <= fz[CW-1:0];
      f_neg_r  <= fneg;
      f_norm_r <= md_norm_r[MS-1];
      f_rt_r   <= md_rt_r[MS-1];
    end
  end

  // rotation mode cordic, one micro-rotation per stage
  logic                 cr_v_r    [CS];
  logic signed [CW-1:0] cr_x_r    [CS];
  logic signed [CW-1:0] cr_y_r    [CS];
  logic signed [CW-1:0] cr_z_r    [CS];
  logic                 cr_neg_r  [CS];
  logic [NB-1:0]        cr_norm_r [CS];
  logic signed [RB-1:0] cr_rt_r   [CS][3];

  for (genvar i = 0; i < CS; i++) begin : g_cordic
    localparam logic signed [CW-1:0] AT = gyrq_pkg::atan_q30(i);
    logic                 v_i, neg_i;
    logic signed [CW-1:0] x_i, y_i, z_i, dx, dy;
    logic [NB-1:0]        norm_i;
    logic signed [RB-1:0] rt_i [3];

    if (i == 0) begin : g_first
      assign v_i    = f_v_r;
      assign x_i    = gyrq_pkg::CORDIC_GAIN_Q30;
      assign y_i    = '0;
      assign z_i    = f_z_r;
      assign neg_i  = f_neg_r;
      assign norm_i = f_norm_r;
      assign rt_i   = f_rt_r;
    end else begin : g_next
      assign v_i    = cr_v_r[i-1];
      assign x_i    = cr_x_r[i-1];
      assign y_i    = cr_y_r[i-1];
      assign z_i    = cr_z_r[i-1];
      assign neg_i  = cr_neg_r[i-1];
      assign norm_i = cr_norm_r[i-1];
      assign rt_i   = cr_rt_r[i-1];
    end

    assign dx = y_i >>> i;
    assign dy = x_i >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) cr_v_r[i] <= 1'b0;
      else if (adv) cr_v_r[i] <= v_i;
      if (adv) begin
        if (!z_i[CW-1]) begin
          cr_x_r[i] <= x_i - dx;
          cr_y_r[i] <= y_i + dy;
          cr_z_r[i] <= z_i - AT;
        end else begin
          cr_x_r[i] <= x_i + dx;
          cr_y_r[i] <= y_i - dy;
          cr_z_r[i] <= z_i + AT;
        end
        cr_neg_r[i]  <= neg_i;
        cr_norm_r[i] <= norm_i;
        cr_rt_r[i]   <= rt_i;
      end
    end
  end

  // undo the fold, form |r|*|s| + norm/2 for each axis
  logic                 m_v_r;
  logic [OUT_BITS-1:0]  m_w_r;
  logic [DW-1:0]        m_num_r [3];
  logic                 m_sgn_r [3];
  logic [NB-1:0]        m_norm_r;
  logic signed [CW-1:0] mx, ms;
  logic [CW-1:0]        mas;
  logic [RB-1:0]        mar [3];
  logic [DW-1:0]        mnum [3];

  always_comb begin
    mx  = cr_neg_r[CS-1] ? -cr_x_r[CS-1] : cr_x_r[CS-1];
    ms  = cr_neg_r[CS-1] ? -cr_y_r[CS-1] : cr_y_r[CS-1];
    mas = ms[CW-1] ? $unsigned(-ms) : $unsigned(ms);
    for (int l = 0; l < 3; l++) begin
      mar[l]  = cr_rt_r[CS-1][l][RB-1] ? $unsigned(-cr_rt_r[CS-1][l])
                                       : $unsigned(cr_rt_r[CS-1][l]);
      mnum[l] = DW'(PW'(mar[l]) * PW'(mas)) + DW'(cr_norm_r[CS-1] >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) m_v_r <= 1'b0;
    else if (adv) m_v_r <= cr_v_r[CS-1];
    if (adv) begin
      m_w_r    <= to_out(VW'(mx));
      m_norm_r <= cr_norm_r[CS-1];
      for (int l = 0; l < 3; l++) begin
        m_num_r[l] <= mnum[l];
        m_sgn_r[l] <= cr_rt_r[CS-1][l][RB-1] != ms[CW-1];
      end
    end
  end

  // restoring divide by norm, three lanes, one quotient bit per stage
  logic                 dv_v_r    [QB];
  logic [DW-1:0]        dv_rem_r  [QB][3];
  logic [QB-1:0]        dv_quo_r  [QB][3];
  logic                 dv_sgn_r  [QB][3];
  logic [OUT_BITS-1:0]  dv_w_r    [QB];
  logic [NB-1:0]        dv_norm_r [QB];

  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int K = QB - 1 - j;
    logic                v_i;
    logic [DW-1:0]       rem_i [3];
    logic [QB-1:0]       quo_i [3];
    logic                sgn_i [3];
    logic [OUT_BITS-1:0] w_i;
    logic [NB-1:0]       norm_i;
    logic [DW-1:0]       dd;

    if (j == 0) begin : g_first
      assign v_i    = m_v_r;
      assign rem_i  = m_num_r;
      assign quo_i  = '{default: '0};
      assign sgn_i  = m_sgn_r;
      assign w_i    = m_w_r;
      assign norm_i = m_norm_r;
    end else begin : g_next
      assign v_i    = dv_v_r[j-1];
      assign rem_i  = dv_rem_r[j-1];
      assign quo_i  = dv_quo_r[j-1];
      assign sgn_i  = dv_sgn_r[j-1];
      assign w_i    = dv_w_r[j-1];
      assign norm_i = dv_norm_r[j-1];
    end

    assign dd = DW'(norm_i) << K;

    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[j] <= 1'b0;
      else if (adv) dv_v_r[j] <= v_i;
      if (adv) begin
        for (int l = 0; l < 3; l++) begin
          if (rem_i[l] >= dd) begin
            dv_rem_r[j][l] <= rem_i[l] - dd;
            dv_quo_r[j][l] <= quo_i[l] | (QB'(1) << K);
          end else begin
            dv_rem_r[j][l] <= rem_i[l];
            dv_quo_r[j][l] <= quo_i[l];
          end
        end
        dv_sgn_r[j]  <= sgn_i;
        dv_w_r[j]    <= w_i;
        dv_norm_r[j] <= norm_i;
      end
    end
  end

  // output register; a zero rate vector gives the identity
  logic                 zero_norm;
  logic signed [VW-1:0] qv [3];
  logic [OUT_BITS-1:0]  qo [3];
  logic [OUT_BITS-1:0]  out_w_r, out_x_r, out_y_r, out_z_r;

  always_comb begin
    zero_norm = dv_norm_r[QB-1] == '0;
    for (int l = 0; l < 3; l++) begin
      qv[l] = $signed(VW'(dv_quo_r[QB-1][l]));
      if (dv_sgn_r[QB-1][l]) qv[l] = -qv[l];
      qo[l] = zero_norm ? '0 : to_out(qv[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= dv_v_r[QB-1];
    if (adv) begin
      out_w_r <= zero_norm ? ONE_OUT : dv_w_r[QB-1];
      out_x_r <= qo[0];
      out_y_r <= qo[1];
      out_z_r <= qo[2];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_quat_w = $signed(out_w_r);
  assign out_quat_x = $signed(out_x_r);
  assign out_quat_y = $signed(out_y_r);
  assign out_quat_z = $signed(out_z_r);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
    sq_v_r[NB-1] |-> sq_rem_r[NB-1] <= (SB'(sq_root_r[NB-1]) << 1))
    else $error("square root remainder too large");

  a_mod_range: assert property (@(posedge clk) disable iff (!rst_n)
    md_v_r[MS-1] |-> md_rem_r[MS-1] < RW'(gyrq_pkg::TWO_PI_Q41))
    else $error("angle not reduced below 2*pi");

  a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
    f_v_r |-> (f_z_r <= ZLIM) && (f_z_r >= -ZLIM))
    else $error("folded angle outside half pi");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    dv_v_r[QB-1] && (dv_norm_r[QB-1] != '0)
      |-> dv_rem_r[QB-1][0] < DW'(dv_norm_r[QB-1]))
    else $error("divider remainder not below norm");

endmodule
